// File: rtl/core/slhs_pkg.sv
// Shared types and constants for the sphere lattice hit scorer.
// No dependencies.
package slhs_pkg;
   localparam int unsigned MaxSideSpheres = 1024;
   localparam int unsigned DiamW = 24;
   localparam int unsigned RadSqW = 46;
   localparam int unsigned CoordW = 32;
   localparam int unsigned SideW = 11;
   localparam int unsigned ScaleW = 32;
   localparam int unsigned EnergyW = 32;
   localparam int unsigned IndexW = 30;
   localparam int unsigned LinealW = 40;
   localparam int unsigned ReqDataW = 128;
   localparam int unsigned RspDataW = 72;
   localparam int unsigned CsrIdxW = 3;
   localparam int unsigned CsrDataW = 46;

   typedef enum logic [CsrIdxW-1:0] {
      REG_DIAMETER = 3'd0,
      REG_RADIUS_SQ = 3'd1,
      REG_ORIGIN = 3'd2,
      REG_SIDE = 3'd3,
      REG_SCALE = 3'd4
   } reg_index_type;
endpackage

// File: rtl/core/sphere_lattice_hit_scorer_core.sv
// Pipeline: 40 register stages from the req transfer to rsp_tvalid;
// one item per cycle while rsp is not stalled. The depth is set by the restoring divider, one quotient bit
// per stage over the 33-bit origin offset, all three axes in parallel.
// A stall on rsp holds the whole pipeline; items without a hit leave no result.
// Reset (synchronous, active high) clears all valid bits and loads register defaults.
// Depends on slhs_pkg.
module sphere_lattice_hit_scorer_core #(
   parameter int unsigned MAX_SIDE_SPHERES = slhs_pkg::MaxSideSpheres
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // energy_deposit[31:0], pos_x[63:32], pos_y[95:64], pos_z[127:96]
   input  logic [slhs_pkg::ReqDataW-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // sphere_index[29:0], lineal_energy[69:30], out_of_grid[70], zero pad
   output logic [slhs_pkg::RspDataW-1:0] rsp_tdata,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [slhs_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [slhs_pkg::CsrDataW-1:0] csr_data
);
   import slhs_pkg::*;

   localparam int unsigned SW = $clog2(MAX_SIDE_SPHERES + 1);
   localparam int unsigned DIV_N = CoordW + 1;
   localparam int unsigned QW = DIV_N + 2;
   localparam int unsigned LW = (3 * SW > IndexW) ? 3 * SW : IndexW;

   // configuration
   logic [DiamW-1:0]  pitch_ff;
   logic [RadSqW-1:0] rad_sq_ff;
   logic [CoordW-1:0] origin_ff;
   logic [SW-1:0]     side_ff;
   logic [ScaleW-1:0] scale_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff <= DiamW'(256);
         rad_sq_ff <= RadSqW'(16384);
         origin_ff <= '0;
         side_ff <= SW'(1);
         scale_ff <= ScaleW'(16777216);
      end else if (csr_valid) begin
         case (csr_index)
            REG_DIAMETER:
               pitch_ff <= (csr_data[DiamW-1:0] == '0) ? DiamW'(1) : csr_data[DiamW-1:0];
            REG_RADIUS_SQ: rad_sq_ff <= csr_data[RadSqW-1:0];
            REG_ORIGIN: origin_ff <= csr_data[CoordW-1:0];
            REG_SIDE: begin
               if ({1'b0, csr_data[SideW-1:0]} > (SideW + 1)'(MAX_SIDE_SPHERES))
                  side_ff <= SW'(MAX_SIDE_SPHERES);
               else
                  side_ff <= SW'(csr_data[SideW-1:0]);
            end
            REG_SCALE: scale_ff <= csr_data[ScaleW-1:0];
            default: ;
         endcase
      end
   end

   logic en;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RspDataW-1:0] rsp_data_ff, rsp_data_in;

   assign en = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   // stage 0: offset from origin
   logic               v0_ff;
   logic [EnergyW-1:0] e0_ff;
   logic signed [CoordW:0] d_ff [3];

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else if (en) v0_ff <= req_tvalid;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         e0_ff <= req_tdata[EnergyW-1:0];
         for (int a = 0; a < 3; a++)
            d_ff[a] <= $signed({req_tdata[CoordW*(a+2)-1], req_tdata[CoordW*(a+1) +: CoordW]})
                     - $signed({origin_ff[CoordW-1], origin_ff});
      end
   end

   // divider: index 0 is the magnitude stage, each step adds one quotient bit
   logic               dv_ff  [DIV_N+1];
   logic [EnergyW-1:0] de_ff  [DIV_N+1];
   logic [2:0]         neg_ff [DIV_N+1];
   logic [DIV_N-1:0]   num_ff [DIV_N+1][3];
   logic [DiamW-1:0]   rem_ff [DIV_N+1][3];
   logic [DIV_N-1:0]   num_in [DIV_N][3];
   logic [DiamW-1:0]   rem_in [DIV_N][3];

   always_comb begin
      logic [DiamW:0] sh;
      logic ge;
      for (int k = 0; k < DIV_N; k++) begin
         for (int a = 0; a < 3; a++) begin
            sh = {rem_ff[k][a], num_ff[k][a][DIV_N-1]};
            ge = sh >= {1'b0, pitch_ff};
            rem_in[k][a] = ge ? DiamW'(sh - {1'b0, pitch_ff}) : sh[DiamW-1:0];
            num_in[k][a] = {num_ff[k][a][DIV_N-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_N; k++) dv_ff[k] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= v0_ff;
         for (int k = 0; k < DIV_N; k++) dv_ff[k+1] <= dv_ff[k];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         de_ff[0] <= e0_ff;
         for (int a = 0; a < 3; a++) begin
            neg_ff[0][a] <= d_ff[a][CoordW];
            num_ff[0][a] <= d_ff[a][CoordW] ? DIV_N'(-d_ff[a]) : DIV_N'(d_ff[a]);
            rem_ff[0][a] <= '0;
         end
         for (int k = 0; k < DIV_N; k++) begin
            de_ff[k+1] <= de_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            for (int a = 0; a < 3; a++) begin
               num_ff[k+1][a] <= num_in[k][a];
               rem_ff[k+1][a] <= rem_in[k][a];
            end
         end
      end
   end

   // floor correction for negative offsets
   logic               vf_ff;
   logic [EnergyW-1:0] ef_ff;
   logic signed [QW-1:0] qf_ff [3];
   logic [DiamW-1:0]   rf_ff [3];

   always_ff @(posedge clock) begin
      if (reset) vf_ff <= 1'b0;
      else if (en) vf_ff <= dv_ff[DIV_N];
   end
   always_ff @(posedge clock) begin
      logic nz;
      if (en) begin
         ef_ff <= de_ff[DIV_N];
         for (int a = 0; a < 3; a++) begin
            nz = rem_ff[DIV_N][a] != '0;
            if (neg_ff[DIV_N][a]) begin
               qf_ff[a] <= -$signed({2'b00, num_ff[DIV_N][a]}) - $signed(QW'(nz));
               rf_ff[a] <= nz ? pitch_ff - rem_ff[DIV_N][a] : '0;
            end else begin
               qf_ff[a] <= $signed({2'b00, num_ff[DIV_N][a]});
               rf_ff[a] <= rem_ff[DIV_N][a];
            end
         end
      end
   end

   // round to nearest, ties to even
   logic               vr_ff;
   logic [EnergyW-1:0] er_ff;
   logic signed [QW-1:0] qr_ff [3];
   logic [DiamW-1:0]   off_ff [3];

   always_ff @(posedge clock) begin
      if (reset) vr_ff <= 1'b0;
      else if (en) vr_ff <= vf_ff;
   end
   always_ff @(posedge clock) begin
      logic [DiamW:0] two_r;
      logic up;
      if (en) begin
         er_ff <= ef_ff;
         for (int a = 0; a < 3; a++) begin
            two_r = {rf_ff[a], 1'b0};
            up = (two_r > {1'b0, pitch_ff}) || (two_r == {1'b0, pitch_ff} && qf_ff[a][0]);
            qr_ff[a] <= qf_ff[a] + $signed(QW'(up));
            off_ff[a] <= up ? pitch_ff - rf_ff[a] : rf_ff[a];
         end
      end
   end

   // squares, grid check, energy scaling
   logic               vs_ff;
   logic               nze_s_ff;
   logic [2*ScaleW-1:0] prod_s_ff;
   logic [2*DiamW-1:0] sq_ff [3];
   logic [SW-1:0]      ix_s_ff [3];
   logic               oog_s_ff;

   always_ff @(posedge clock) begin
      if (reset) vs_ff <= 1'b0;
      else if (en) vs_ff <= vr_ff;
   end
   always_ff @(posedge clock) begin
      logic o;
      if (en) begin
         nze_s_ff <= er_ff != '0;
         prod_s_ff <= er_ff * scale_ff;
         o = 1'b0;
         for (int a = 0; a < 3; a++) begin
            sq_ff[a] <= off_ff[a] * off_ff[a];
            ix_s_ff[a] <= qr_ff[a][SW-1:0];
            if (qr_ff[a][QW-1] || ($unsigned(qr_ff[a]) >= QW'(side_ff))) o = 1'b1;
         end
         oog_s_ff <= o;
      end
   end

   // distance compare, first index products
   logic               vd_ff;
   logic               hit_d_ff;
   logic [LinealW-1:0] lin_d_ff;
   logic               oog_d_ff;
   logic [SW-1:0]      ix_d_ff, iz_d_ff;
   logic [2*SW-1:0]    ysd_ff, ssq_d_ff;

   always_ff @(posedge clock) begin
      if (reset) vd_ff <= 1'b0;
      else if (en) vd_ff <= vs_ff;
   end
   always_ff @(posedge clock) begin
      logic [2*DiamW+1:0] sum_sq;
      if (en) begin
         sum_sq = (2*DiamW+2)'(sq_ff[0]) + (2*DiamW+2)'(sq_ff[1]) + (2*DiamW+2)'(sq_ff[2]);
         hit_d_ff <= nze_s_ff && (sum_sq <= (2*DiamW+2)'(rad_sq_ff));
         lin_d_ff <= prod_s_ff[2*ScaleW-1:24];
         oog_d_ff <= oog_s_ff;
         ix_d_ff <= ix_s_ff[0];
         iz_d_ff <= ix_s_ff[2];
         ysd_ff <= ix_s_ff[1] * side_ff;
         ssq_d_ff <= side_ff * side_ff;
      end
   end

   // final index and output register
   always_comb begin
      logic [LW-1:0] idx;
      idx = LW'(ix_d_ff) + LW'(ysd_ff) + LW'(iz_d_ff) * LW'(ssq_d_ff);
      if (oog_d_ff) idx = '0;
      rsp_data_in = {1'b0, oog_d_ff, lin_d_ff, idx[IndexW-1:0]};
      rsp_valid_in = vd_ff && hit_d_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= rsp_valid_in;
   end
   always_ff @(posedge clock) begin
      if (en) rsp_data_ff <= rsp_data_in;
   end
endmodule
